FILE: src/tlvp_pkg.sv
// Shared types and constants for the type-length-value message parser.
`default_nettype none
package tlvp_pkg;

	localparam int unsigned CNT_W = 17;

	localparam logic [CNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
	localparam logic [CNT_W-1:0] HEADER_LEN = 17'd3;
	localparam logic [15:0]      NEED_SHORT = 16'd4;
	localparam logic [15:0]      NEED_REPLY = 16'd10;

	localparam logic [CNT_W-1:0] OFF_ADDR_END = 17'd4;
	localparam logic [CNT_W-1:0] OFF_PORT_END = 17'd6;
	localparam logic [CNT_W-1:0] OFF_KEY_END  = 17'd10;

	localparam logic [CNT_W-1:0] POS_TYPE   = 17'd0;
	localparam logic [CNT_W-1:0] POS_LEN_HI = 17'd1;
	localparam logic [CNT_W-1:0] POS_LEN_LO = 17'd2;

	typedef enum logic [1:0] {
		CFG_REQUEST   = 2'd0,
		CFG_REPLY     = 2'd1,
		CFG_KEEPALIVE = 2'd2,
		CFG_SPARE     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LEN_ERR  = 2'd1,
		ST_UNKNOWN  = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] request_code;
		logic [7:0] reply_code;
		logic [7:0] keepalive_code;
	} codes_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  msg_type;
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
		logic [31:0] tunnel_key;
		logic [31:0] keepalive_token;
	} result_t;

endpackage
`default_nettype wire

FILE: src/tlvp_cfg.sv
// Type code registers written through the configuration channel.
`default_nettype none
module tlvp_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_index,
	input  wire logic [7:0]    wr_data,
	output tlvp_pkg::codes_t   codes
);

	tlvp_pkg::codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.request_code   <= 8'd1;
			codes_q.reply_code     <= 8'd2;
			codes_q.keepalive_code <= 8'd3;
		end else if (wr_en) begin
			case (tlvp_pkg::cfg_index_t'(wr_index))
				tlvp_pkg::CFG_REQUEST:   codes_q.request_code   <= wr_data;
				tlvp_pkg::CFG_REPLY:     codes_q.reply_code     <= wr_data;
				tlvp_pkg::CFG_KEEPALIVE: codes_q.keepalive_code <= wr_data;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;

endmodule
`default_nettype wire

FILE: src/tlvp_parse.sv
// Header and field capture per byte, and result classification on the last byte.
`default_nettype none
module tlvp_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last_byte,
	input  tlvp_pkg::codes_t   codes,
	output logic               res_valid,
	output tlvp_pkg::result_t  res
);

	logic [tlvp_pkg::CNT_W-1:0] byte_count_q, cnt_d, off;
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [31:0] addr_q, addr_d;
	logic [15:0] port_q, port_d;
	logic [31:0] word_q, word_d;
	logic        len_err;

	always_comb begin
		type_d = type_q;
		len_d  = len_q;
		addr_d = addr_q;
		port_d = port_q;
		word_d = word_q;
		off    = byte_count_q - tlvp_pkg::HEADER_LEN;
		if (byte_count_q == tlvp_pkg::POS_TYPE) begin
			type_d = data_byte;
		end else if (byte_count_q == tlvp_pkg::POS_LEN_HI) begin
			len_d = {data_byte, 8'd0};
		end else if (byte_count_q == tlvp_pkg::POS_LEN_LO) begin
			len_d = {len_q[15:8], data_byte};
		end else if (off < {1'b0, len_q}) begin
			if (off < tlvp_pkg::OFF_ADDR_END) begin
				addr_d = {addr_q[23:0], data_byte};
			end else if (off < tlvp_pkg::OFF_PORT_END) begin
				port_d = {port_q[7:0], data_byte};
			end else if (off < tlvp_pkg::OFF_KEY_END) begin
				word_d = {word_q[23:0], data_byte};
			end
		end
		cnt_d = (byte_count_q == tlvp_pkg::COUNT_MAX) ? byte_count_q
			: byte_count_q + 1'b1;

		len_err = (cnt_d < tlvp_pkg::HEADER_LEN)
			|| ({1'b0, len_d} > (cnt_d - tlvp_pkg::HEADER_LEN));

		res = '0;
		res.status = tlvp_pkg::ST_OK;
		if (len_err) begin
			res.status = tlvp_pkg::ST_LEN_ERR;
		end else begin
			res.msg_type = type_d;
			if (type_d == codes.request_code) begin
				if (len_d < tlvp_pkg::NEED_SHORT) res.status = tlvp_pkg::ST_OVERRUN;
				else res.peer_addr = addr_d;
			end else if (type_d == codes.reply_code) begin
				if (len_d < tlvp_pkg::NEED_REPLY) begin
					res.status = tlvp_pkg::ST_OVERRUN;
				end else begin
					res.peer_addr  = addr_d;
					res.peer_port  = port_d;
					res.tunnel_key = word_d;
				end
			end else if (type_d == codes.keepalive_code) begin
				if (len_d < tlvp_pkg::NEED_SHORT) res.status = tlvp_pkg::ST_OVERRUN;
				else res.keepalive_token = addr_d;
			end else begin
				res.status = tlvp_pkg::ST_UNKNOWN;
			end
		end
		res_valid = accept && last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			type_q       <= '0;
			len_q        <= '0;
			addr_q       <= '0;
			port_q       <= '0;
			word_q       <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_count_q <= '0;
				type_q       <= '0;
				len_q        <= '0;
				addr_q       <= '0;
				port_q       <= '0;
				word_q       <= '0;
			end else begin
				byte_count_q <= cnt_d;
				type_q       <= type_d;
				len_q        <= len_d;
				addr_q       <= addr_d;
				port_q       <= port_d;
				word_q       <= word_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/tlvp_skid.sv
// Result output register with a skid entry so input stall is registered.
`default_nettype none
module tlvp_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  tlvp_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tlvp_pkg::result_t  out_data
);

	logic              out_valid_q, skid_valid_q;
	tlvp_pkg::result_t out_data_q, skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) out_data_q <= skid_data_q;
			else if (push) out_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

FILE: src/tlv_message_parser_top.sv
// Top level of the type-length-value message parser.
// Takes one byte per clock while in_stall is low: a type byte, a big-endian
// 16-bit length, then payload. The result for a buffer is registered into the
// output register behind out_valid; a second result can wait in a skid entry,
// and in_stall rises only while that entry is occupied. Writes to the type code
// registers are always ready and take effect from the next byte on.
`default_nettype none
module tlv_message_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       msg_type,
	output logic [31:0]      peer_addr,
	output logic [15:0]      peer_port,
	output logic [31:0]      tunnel_key,
	output logic [31:0]      keepalive_token
);

	tlvp_pkg::codes_t  codes;
	tlvp_pkg::result_t res, out_res;
	logic              res_valid, accept, full;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	tlvp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.codes    (codes)
	);

	tlvp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.codes     (codes),
		.res_valid (res_valid),
		.res       (res)
	);

	tlvp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign status          = out_res.status;
	assign msg_type        = out_res.msg_type;
	assign peer_addr       = out_res.peer_addr;
	assign peer_port       = out_res.peer_port;
	assign tunnel_key      = out_res.tunnel_key;
	assign keepalive_token = out_res.keepalive_token;

endmodule
`default_nettype wire

FILE: src/tlvp_checker.sv
// Port-level checks for the parser top level and their bind.
`default_nettype none
module tlvp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  data_byte,
	input wire logic        last_byte,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [7:0]  msg_type,
	input wire logic [31:0] peer_addr,
	input wire logic [15:0] peer_port,
	input wire logic [31:0] tunnel_key,
	input wire logic [31:0] keepalive_token
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(msg_type)
			&& $stable(peer_addr) && $stable(keepalive_token))
		else $error("stalled result beat changed");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(last_byte))
		else $error("stalled input beat changed");

	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && $past(out_valid))
		else $error("input stalled with empty output register");

	a_len_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tlvp_pkg::ST_LEN_ERR |-> msg_type == 8'd0
			&& peer_addr == 32'd0 && keepalive_token == 32'd0)
		else $error("length error beat carries field data");

	a_error_no_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tlvp_pkg::ST_OK |-> peer_port == 16'd0
			&& tunnel_key == 32'd0 && peer_addr == 32'd0)
		else $error("error beat carries field data");

endmodule

bind tlv_message_parser_top tlvp_checker u_tlvp_checker (.*);
`default_nettype wire
